>>> hw/rtl/mhpq_pkg.sv
// Shared types and codes for the min-heap priority queue.
// No dependencies.
`timescale 1ns / 1ps
package mhpq_pkg;
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELKEY = 2'd1;
  localparam logic [1:0] ACT_DELMIN = 2'd2;
  localparam logic [1:0] ACT_READ   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_SCAN, S_SCAN_CMP, S_LAST_RD, S_LAST_WR,
    S_DN_RD, S_DN_RD2, S_DN_CMP, S_ROOT_RD, S_DONE
  } state_e;
endpackage

>>> hw/rtl/mhpq_ram.sv
// Generic single-port synchronous RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps
module mhpq_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

>>> hw/rtl/min_heap_priority_queue.sv
// Min-heap priority queue top level: sequencer around one heap RAM.
// Depends on mhpq_pkg and mhpq_ram.
//
// channel | ports                            | handshake
// command | action_i, key_i                  | start_i & !busy_o
// result  | min_value_o, entry_total_o, status_o | done_o, one cycle
//
// Steps from accept to result beat: read fetches the root; insert reads one
// parent per level climbed; delete-min moves the last entry in and reads
// the children per level descended; delete-by-key first scans the entries.
// Reset clears the count and the sequencer; RAM data of unwritten slots is
// never used. Results cannot be stalled; busy_o holds off the next command.
`timescale 1ns / 1ps
module min_heap_priority_queue
  import mhpq_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  action_i,
  input  logic signed [31:0] key_i,
  output logic        done_o,
  output logic signed [31:0] min_value_o,
  output logic [10:0] entry_total_o,
  output logic [1:0]  status_o
);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] i_q, i_d;      // current slot
  logic [CW-1:0] c_q, c_d;      // chosen child / parent
  logic [31:0] cur_q, cur_d;    // value travelling through the heap (flipped)
  logic [31:0] kid_q, kid_d;    // left child value
  logic [31:0] key_q, key_d;
  logic [1:0]  st_q, st_d;
  logic signed [31:0] min_q, min_d;
  logic done_q, done_d;
  // marks a sift-up started by a delete; falls back to sift-down if no move
  logic dn_q;

  logic          we;
  logic [AW-1:0] addr;
  logic [31:0]   wdata, rdata;

  mhpq_ram #(.Width(32), .Depth(CAPACITY)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  logic [CW:0] lchild;
  assign lchild = {i_q, 1'b1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; c_q <= c_d; cur_q <= cur_d; kid_q <= kid_d;
    key_q <= key_d; st_q <= st_d; min_q <= min_d;
  end

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; i_d = i_q; c_d = c_q;
    cur_d = cur_q; kid_d = kid_q; key_d = key_q; st_d = st_q;
    min_d = min_q; done_d = 1'b0;
    we = 1'b0; addr = i_q[AW-1:0]; wdata = cur_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          key_d = {~key_i[31], key_i[30:0]};
          st_d = ST_OK;
          i_d = '0;
          unique case (action_i)
            ACT_INSERT: begin
              if (cnt_q >= CW'(CAPACITY)) begin
                st_d = ST_FULL; state_d = S_ROOT_RD;
              end else begin
                i_d = cnt_q; cur_d = {~key_i[31], key_i[30:0]};
                cnt_d = cnt_q + 1'b1; state_d = S_UP_RD;
              end
            end
            ACT_DELKEY: begin
              if (cnt_q == '0) begin
                st_d = ST_EMPTY; state_d = S_ROOT_RD;
              end else state_d = S_SCAN;
            end
            ACT_DELMIN: begin
              if (cnt_q == '0) begin
                st_d = ST_EMPTY; state_d = S_ROOT_RD;
              end else state_d = S_LAST_RD;
            end
            default: state_d = S_ROOT_RD;
          endcase
        end
      end
      // sift up: hold value in cur_q, move larger parents down, write it at final slot
      S_UP_RD: begin
        if (i_q == '0) begin
          we = 1'b1; state_d = S_ROOT_RD;
        end else begin
          c_d = (i_q - 1'b1) >> 1;
          addr = AW'((i_q - 1'b1) >> 1);
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (cur_q < rdata) begin
          we = 1'b1; wdata = rdata; i_d = c_q; state_d = S_UP_RD;
        end else begin
          we = 1'b1; state_d = S_ROOT_RD;
        end
      end
      S_SCAN: state_d = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (rdata == key_q) state_d = S_LAST_RD;
        else if (i_q + 1'b1 >= cnt_q) begin
          st_d = ST_MISSING; state_d = S_ROOT_RD;
        end else begin
          i_d = i_q + 1'b1; state_d = S_SCAN;
        end
      end
      S_LAST_RD: begin
        addr = AW'(cnt_q - 1'b1);
        cnt_d = cnt_q - 1'b1;
        state_d = (i_q == cnt_q - 1'b1) ? S_ROOT_RD : S_LAST_WR;
      end
      S_LAST_WR: begin
        cur_d = rdata;
        // sift up first; if it does not move, sift down from i
        if (i_q == '0) state_d = S_DN_RD;
        else begin
          c_d = (i_q - 1'b1) >> 1; addr = AW'((i_q - 1'b1) >> 1);
          state_d = S_UP_CMP;
        end
      end
      S_DN_RD: begin
        if (lchild >= (CW+1)'(cnt_q)) begin
          we = 1'b1; state_d = S_ROOT_RD;
        end else begin
          addr = AW'(lchild); c_d = CW'(lchild); state_d = S_DN_RD2;
        end
      end
      S_DN_RD2: begin
        kid_d = rdata;
        if (CW'(lchild) + 1'b1 < cnt_q) begin
          addr = AW'(lchild + 1'b1); state_d = S_DN_CMP;
        end else begin
          state_d = S_DN_CMP; kid_d = rdata; c_d = CW'(lchild);
          st_d = st_q;
        end
      end
      S_DN_CMP: begin
        if ((CW'(lchild) + 1'b1 < cnt_q) && (rdata < kid_q)) begin
          if (rdata < cur_q) begin
            we = 1'b1; wdata = rdata; i_d = CW'(lchild) + 1'b1; state_d = S_DN_RD;
          end else begin
            we = 1'b1; state_d = S_ROOT_RD;
          end
        end else if (kid_q < cur_q) begin
          we = 1'b1; wdata = kid_q; i_d = CW'(lchild); state_d = S_DN_RD;
        end else begin
          we = 1'b1; state_d = S_ROOT_RD;
        end
      end
      S_ROOT_RD: begin addr = '0; state_d = S_DONE; end
      S_DONE: begin
        min_d = (cnt_q == '0) ? 32'sd0 : $signed({~rdata[31], rdata[30:0]});
        done_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    // UP_CMP reached from a delete: if value did not move up, sift down instead
    if (state_q == S_UP_CMP && !(cur_q < rdata) && dn_q) begin
      we = 1'b0; state_d = S_DN_RD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dn_q <= 1'b0;
    else if (state_q == S_LAST_WR) dn_q <= 1'b1;
    else if (state_q == S_UP_CMP) dn_q <= 1'b0;
    else if (state_q == S_IDLE) dn_q <= 1'b0;
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign min_value_o   = min_q;
  assign entry_total_o = 11'(cnt_q);
  assign status_o      = st_q;
endmodule

>>> hw/rtl/mhpq_checker.sv
// Port-level checker for the min-heap priority queue, bound to the top.
// Depends on mhpq_pkg.
`timescale 1ns / 1ps
module mhpq_checker
  import mhpq_pkg::*;
(
  input logic clk_i, rst_ni, start_i, busy_o, done_o,
  input logic signed [31:0] min_value_o,
  input logic [10:0] entry_total_o,
  input logic [1:0] status_o
);
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("no busy after start");
  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("busy during done");
  a_empty_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && entry_total_o == 11'd0 |-> min_value_o == 32'sd0)
    else $error("nonzero min on empty");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ST_OK |-> entry_total_o == $past(entry_total_o, 1))
    else $error("count moved on reject");
endmodule

bind min_heap_priority_queue mhpq_checker u_chk (
  .clk_i, .rst_ni, .start_i, .busy_o, .done_o,
  .min_value_o, .entry_total_o, .status_o
);
